// File: rtl/dll_pkg.sv
// Shared types and codes for the doubly linked list engine.
// No dependencies.
package dll_pkg;

  localparam int POOL_NODES_DEF = 16;

  typedef enum logic [2:0] {
    ACT_ADD_HEAD  = 3'd0,
    ACT_ADD_TAIL  = 3'd1,
    ACT_ADD_AFTER = 3'd2,
    ACT_DEL_HEAD  = 3'd3,
    ACT_DEL_TAIL  = 3'd4,
    ACT_DEL_TGT   = 3'd5,
    ACT_EDIT      = 3'd6,
    ACT_READ_ALL  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]   action;
    logic signed [31:0] target;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]   status;
    logic signed [31:0] item;
    logic         final_res;
  } out_beat_t;

endpackage

// File: rtl/doubly_linked_list_engine.sv
// Doubly linked list engine: node pool in memories, walked by a sequencer.
// Walks visit each node by a registered memory read, then a compare; the free
// slot scan tests the slots in turn from the lowest. busy drops in the cycle of
// the final result, so the next command can be taken there. Results cannot be
// stalled.
// Synchronous reset empties the list at once; node memories need no clearing.
// Depends on dll_pkg and dll_slot_alloc.
module doubly_linked_list_engine #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dll_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  output dll_pkg::out_beat_t  out_beat
);
  import dll_pkg::*;

  localparam int IW = $clog2(POOL_NODES) + 1;
  localparam int AW = IW - 1;
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_ALLOC = 9'b000001000,
    S_LINK  = 9'b000010000,
    S_FIX   = 9'b000100000,
    S_UNRD  = 9'b001000000,
    S_UNLK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] val_mem [POOL_NODES];
  logic [IW-1:0]      nxt_mem [POOL_NODES];
  logic [IW-1:0]      prv_mem [POOL_NODES];

  logic [POOL_NODES-1:0] used_r;
  logic [IW-1:0] head_r, tail_r, cur_r, slot_r, p_r, q_r;
  logic [IW:0]   steps_r;
  action_t       act_r;
  logic signed [31:0] tgt_r, val_r;
  logic signed [31:0] rd_val;
  logic [IW-1:0] rd_nxt, rd_prv;
  logic [1:0]    st_r;

  // one write port per memory, driven by the sequencer
  logic          wv_en, wn_en, wp_en;
  logic [AW-1:0] wv_a, wn_a, wp_a;
  logic signed [31:0] wv_d;
  logic [IW-1:0] wn_d, wp_d;
  logic [AW-1:0] ra;

  logic alloc_go, alloc_done;
  logic [IW-1:0] alloc_slot;

  dll_slot_alloc #(.POOL_NODES(POOL_NODES), .IW(IW)) u_alloc (
    .clk(clk), .rst_n(rst_n), .go(alloc_go), .used(used_r),
    .done(alloc_done), .slot(alloc_slot)
  );

  function automatic logic live(input logic [IW-1:0] n,
                                input logic [POOL_NODES-1:0] u);
    live = (n < NIL) && u[n[AW-1:0]];
  endfunction

  assign busy = (state_r != S_IDLE);
  assign ra   = cur_r[AW-1:0];

  always_ff @(posedge clk) begin
    rd_val <= val_mem[ra];
    rd_nxt <= nxt_mem[ra];
    rd_prv <= prv_mem[ra];
    if (wv_en) val_mem[wv_a] <= wv_d;
    if (wn_en) nxt_mem[wn_a] <= wn_d;
    if (wp_en) prv_mem[wp_a] <= wp_d;
  end

  logic [POOL_NODES-1:0] used_nxt;
  logic [IW-1:0] head_nxt, tail_nxt, cur_nxt, slot_nxt, p_nxt, q_nxt;
  logic [IW:0]   steps_nxt;
  logic [1:0]    st_nxt;
  logic          ov_nxt, ov_r;
  out_beat_t     ob_nxt, ob_r;
  logic          found;

  assign out_valid = ov_r;
  assign out_beat  = ob_r;

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    slot_nxt  = slot_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    steps_nxt = steps_r;
    st_nxt    = st_r;
    ov_nxt    = 1'b0;
    ob_nxt    = '0;
    alloc_go  = 1'b0;
    wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
    wv_a = slot_r[AW-1:0]; wn_a = slot_r[AW-1:0]; wp_a = slot_r[AW-1:0];
    wv_d = val_r; wn_d = q_r; wp_d = p_r;
    found = (rd_val == tgt_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_nxt   = head_r;
          steps_nxt = '0;
          st_nxt    = ST_OK;
          unique case (action_t'(in_beat.action))
            ACT_ADD_HEAD, ACT_ADD_TAIL: begin
              alloc_go  = 1'b1;
              state_nxt = S_ALLOC;
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL: begin
              cur_nxt = (in_beat.action == ACT_DEL_HEAD) ? head_r : tail_r;
              if (!live(cur_nxt, used_r)) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_UNRD;
              end
            end
            ACT_READ_ALL, ACT_DEL_TGT: begin
              if (!live(head_r, used_r)) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              if (!live(head_r, used_r)) begin
                st_nxt    = ST_NOT_FOUND;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        steps_nxt = steps_r + 1'b1;
        if (act_r == ACT_READ_ALL) begin
          ov_nxt           = 1'b1;
          ob_nxt.status    = ST_OK;
          ob_nxt.item      = rd_val;
          cur_nxt          = rd_nxt;
          if (!live(rd_nxt, used_r) || steps_nxt == (IW+1)'(POOL_NODES)) begin
            ob_nxt.final_res = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end else if (found) begin
          unique case (act_r)
            ACT_EDIT: begin
              wv_en     = 1'b1;
              wv_a      = cur_r[AW-1:0];
              state_nxt = S_DONE;
            end
            ACT_ADD_AFTER: begin
              p_nxt     = cur_r;
              q_nxt     = rd_nxt;
              alloc_go  = 1'b1;
              state_nxt = S_ALLOC;
            end
            default: begin
              state_nxt = S_UNLK;
            end
          endcase
        end else begin
          cur_nxt = rd_nxt;
          if (!live(rd_nxt, used_r) || steps_nxt == (IW+1)'(POOL_NODES)) begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_ALLOC: begin
        if (alloc_done) begin
          slot_nxt = alloc_slot;
          if (alloc_slot == NIL) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            if (act_r == ACT_ADD_HEAD) begin
              p_nxt = NIL;
              q_nxt = head_r;
            end else if (act_r == ACT_ADD_TAIL) begin
              p_nxt = tail_r;
              q_nxt = NIL;
            end
            state_nxt = S_LINK;
          end
        end
      end
      S_LINK: begin
        // new node: value and next, plus successor back-link; prev and predecessor link in S_FIX
        wv_en = 1'b1; wn_en = 1'b1;
        wp_en = live(q_r, used_r);
        wp_a  = q_r[AW-1:0];
        wp_d  = slot_r;
        if (!live(q_r, used_r)) tail_nxt = slot_r;
        if (!live(p_r, used_r)) head_nxt = slot_r;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        wp_en = 1'b1;
        if (live(p_r, used_r)) begin
          wn_en = 1'b1;
          wn_a  = p_r[AW-1:0];
          wn_d  = slot_r;
        end
        used_nxt[slot_r[AW-1:0]] = 1'b1;
        state_nxt = S_DONE;
      end
      S_UNRD: state_nxt = S_UNLK;
      S_UNLK: begin
        // cur is unchanged since the last cycle, so rd_prv/rd_nxt are its links
        if (live(rd_prv, used_r)) begin
          wn_en = 1'b1; wn_a = rd_prv[AW-1:0]; wn_d = rd_nxt;
        end
        if (live(rd_nxt, used_r)) begin
          wp_en = 1'b1; wp_a = rd_nxt[AW-1:0]; wp_d = rd_prv;
        end
        head_nxt = live(rd_prv, used_r) ? head_r :
                   (live(rd_nxt, used_r) ? rd_nxt : NIL);
        tail_nxt = live(rd_nxt, used_r) ? tail_r :
                   (live(rd_prv, used_r) ? rd_prv : NIL);
        used_nxt[cur_r[AW-1:0]] = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt           = 1'b1;
        ob_nxt.status    = st_r;
        ob_nxt.final_res = 1'b1;
        state_nxt        = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      head_r  <= NIL;
      tail_r  <= NIL;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r    <= ob_nxt;
    cur_r   <= cur_nxt;
    slot_r  <= slot_nxt;
    steps_r <= steps_nxt;
    st_r    <= st_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    if (state_r == S_IDLE && start) begin
      act_r <= action_t'(in_beat.action);
      tgt_r <= in_beat.target;
      val_r <= in_beat.value;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.final_res |-> !busy)
    else $error("final result while still busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (tail_r == NIL))
    else $error("head and tail disagree on empty");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy)
    else $error("command not taken");
endmodule

// File: rtl/dll_slot_alloc.sv
// Lowest free slot finder for the node pool, scanned one slot per cycle.
// Depends on dll_pkg.
module dll_slot_alloc #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  parameter int IW = $clog2(POOL_NODES) + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [POOL_NODES-1:0] used,
  output logic                  done,
  output logic [IW-1:0]         slot
);
  import dll_pkg::*;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          run_r, run_nxt;
  logic          hit;

  assign hit  = run_r && (idx_r == IW'(POOL_NODES) || !used[idx_r[IW-2:0]]);
  assign done = hit;
  assign slot = idx_r;

  always_comb begin
    idx_nxt = idx_r;
    run_nxt = run_r;
    if (go) begin
      idx_nxt = '0;
      run_nxt = 1'b1;
    end else if (hit) begin
      run_nxt = 1'b0;
    end else if (run_r) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
    end else begin
      run_r <= run_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule
